// File: rtl/core/prsa_pkg.sv
// Shared types, constants and digit helpers for the serial clock access block.
// No dependencies; imported by prsa_snapshot and phantom_rtc_serial_access.
`default_nettype none

package prsa_pkg;

    localparam logic [63:0] UNLOCK_KEY = 64'h5CA3_3AC5_5CA3_3AC5;
    localparam logic [5:0]  FULL_COUNT = 6'd63;

    localparam int          CFG_ADDR_W         = 3;
    localparam int          CFG_DATA_W         = 32;
    localparam logic        REG_IDX_WRITE_EN   = 1'b0;

    typedef enum logic [1:0] {
        REQ_WR0  = 2'd0,
        REQ_WR1  = 2'd1,
        REQ_RD   = 2'd2,
        REQ_NONE = 2'd3
    } t_req;

    typedef struct packed {
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [2:0] weekday;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [6:0] hundredths;
    } t_time_now;

    typedef struct packed {
        logic       read_bit;
        logic       time_written;
        logic [7:0] years;
        logic [7:0] month;
        logic [7:0] day;
        logic [3:0] weekday;
        logic [5:0] hour;
        logic [7:0] minute;
        logic [7:0] second;
        logic [7:0] hundredths;
    } t_result;

    // v / 10 for v < 128 via reciprocal multiply
    function automatic logic [3:0] f_div10(input logic [6:0] v);
        logic [14:0] p;
        p = {8'd0, v} * 15'd205;
        return p[14:11];
    endfunction

    function automatic logic [3:0] f_mod10(input logic [6:0] v);
        logic [6:0] t10;
        logic [6:0] r;
        t10 = {f_div10(v), 3'b000} + {2'b00, f_div10(v), 1'b0};
        r   = v - t10;
        return r[3:0];
    endfunction

    // ones nibble plus ten times tens nibble
    function automatic logic [7:0] f_two(input logic [3:0] hi, input logic [3:0] lo);
        return {4'd0, lo} + {1'b0, hi, 3'b000} + {3'b000, hi, 1'b0};
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/prsa_snapshot.sv
// Packs the current time into the 64-bit BCD read-out word.
// Depends on prsa_pkg (t_time_now, digit helpers).
`default_nettype none

module prsa_snapshot
    import prsa_pkg::*;
(
    input  wire t_time_now   i_now,
    input  wire              i_twelve_hour,
    output logic [63:0]      o_word
);

    logic [6:0] year_m;
    logic [4:0] hour_adj;
    logic       pm;
    logic [3:0] hour_tens;
    logic [3:0] year_tens;

    always_comb begin
        year_m = (i_now.year >= 7'd100) ? (i_now.year - 7'd100) : i_now.year;
        pm       = i_twelve_hour && (i_now.hour > 5'd12);
        hour_adj = pm ? (i_now.hour - 5'd12) : i_now.hour;
        hour_tens = f_div10({2'b00, hour_adj});
        year_tens = f_div10(year_m) + 4'd10;

        o_word = {
            year_tens,
            f_mod10(year_m),
            f_div10({3'b000, i_now.month}),
            f_mod10({3'b000, i_now.month}),
            f_div10({2'b00, i_now.day}),
            f_mod10({2'b00, i_now.day}),
            4'd0,
            {1'b0, i_now.weekday},
            {2'b00, hour_tens[1] | pm, hour_tens[0]},
            f_mod10({2'b00, hour_adj}),
            f_div10({1'b0, i_now.minute}),
            f_mod10({1'b0, i_now.minute}),
            f_div10({1'b0, i_now.second}),
            f_mod10({1'b0, i_now.second}),
            f_div10(i_now.hundredths),
            f_mod10(i_now.hundredths)
        };
    end

endmodule

`default_nettype wire

// File: rtl/core/phantom_rtc_serial_access.sv
// Top level of the serial clock access block: input register, access logic, result register.
// Depends on prsa_pkg and prsa_snapshot.
//
// Every bus access is one item and yields exactly one result item. Items are taken one per
// cycle; each item passes through the input register, then the result register, and the
// single access stage between them handles any kind of access combinationally, so the
// sustained rate is one item per clock while the result side keeps taking. The input
// register also holds one item while a result is stalled. Write-zero/write-one accesses shift
// the key register; a key match snapshots the supplied time for serial read-out, LSB first,
// and 64 further writes after unlock set a new time, reported when write_enable is 1.
`default_nettype none

module phantom_rtc_serial_access
    import prsa_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,

    input  wire                   i_valid,
    output logic                  o_ready,
    input  wire  [1:0]            i_req_type,
    input  wire  [6:0]            i_year_in_century,
    input  wire  [3:0]            i_month_now,
    input  wire  [4:0]            i_day_now,
    input  wire  [2:0]            i_weekday_now,
    input  wire  [4:0]            i_hour_now,
    input  wire  [5:0]            i_minute_now,
    input  wire  [5:0]            i_second_now,
    input  wire  [6:0]            i_hundredths_now,

    output logic                  o_valid,
    input  wire                   i_ready,
    output logic                  o_read_bit,
    output logic                  o_time_written,
    output logic [7:0]            o_set_years_since_1900,
    output logic [7:0]            o_set_month,
    output logic [7:0]            o_set_day,
    output logic [3:0]            o_set_weekday,
    output logic [5:0]            o_set_hour,
    output logic [7:0]            o_set_minute,
    output logic [7:0]            o_set_second,
    output logic [7:0]            o_set_hundredths,

    input  wire                   psel,
    input  wire                   penable,
    input  wire                   pwrite,
    input  wire  [CFG_ADDR_W-1:0] paddr,
    input  wire  [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    // config
    logic r_write_enable;

    // input register
    logic      r_in_v;
    t_req      r_req;
    t_time_now r_now;

    // access state
    logic [63:0] r_match, n_match;
    logic [63:0] r_oshift, n_oshift;
    logic [5:0]  r_bits, n_bits;
    logic        r_unlocked, n_unlocked;
    logic        r_twelve, n_twelve;

    // result register
    logic    r_out_v;
    t_result r_out, n_out;

    logic        fire;
    logic        is_wr;
    logic        do_decode;
    logic [63:0] shifted;
    logic        twelve_eff;
    logic [63:0] snap_word;
    logic [3:0]  hr_t;
    logic [5:0]  dec_hour;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_IDX_WRITE_EN) ? {{(CFG_DATA_W-1){1'b0}}, r_write_enable}
                                                   : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_enable <= 1'b0;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_IDX_WRITE_EN)) begin
            r_write_enable <= pwdata[0];
        end
    end

    assign fire    = r_in_v && (!r_out_v || i_ready);
    assign o_ready = !r_in_v || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (o_ready) begin
            r_in_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_req            <= t_req'(i_req_type);
            r_now.year       <= i_year_in_century;
            r_now.month      <= i_month_now;
            r_now.day        <= i_day_now;
            r_now.weekday    <= i_weekday_now;
            r_now.hour       <= i_hour_now;
            r_now.minute     <= i_minute_now;
            r_now.second     <= i_second_now;
            r_now.hundredths <= i_hundredths_now;
        end
    end

    assign is_wr      = (r_req == REQ_WR0) || (r_req == REQ_WR1);
    assign shifted    = {r_req[0], r_match[63:1]};
    assign do_decode  = is_wr && r_unlocked && (r_bits == 6'd0);
    assign hr_t       = shifted[31:28];
    assign twelve_eff = do_decode ? hr_t[3] : r_twelve;

    always_comb begin
        if (hr_t[3]) begin
            dec_hour = {2'b00, shifted[27:24]} + (hr_t[0] ? 6'd10 : 6'd0)
                     + (hr_t[1] ? 6'd12 : 6'd0);
        end else begin
            dec_hour = {2'b00, shifted[27:24]} + {1'b0, hr_t[1:0], 3'b000}
                     + {3'b000, hr_t[1:0], 1'b0};
        end
    end

    prsa_snapshot u_snapshot (
        .i_now         (r_now),
        .i_twelve_hour (twelve_eff),
        .o_word        (snap_word)
    );

    always_comb begin
        n_match    = r_match;
        n_oshift   = r_oshift;
        n_bits     = r_bits;
        n_unlocked = r_unlocked;
        n_twelve   = r_twelve;
        n_out      = '0;
        if (fire) begin
            case (r_req)
                REQ_WR0, REQ_WR1: begin
                    n_match = shifted;
                    if (r_unlocked) begin
                        if (r_bits == 6'd0) begin
                            n_unlocked = 1'b0;
                            n_twelve   = hr_t[3];
                            if (r_write_enable) begin
                                n_out.time_written = 1'b1;
                                n_out.years        = f_two(shifted[63:60], shifted[59:56]);
                                n_out.month        = f_two(shifted[55:52], shifted[51:48]);
                                n_out.day          = f_two(shifted[47:44], shifted[43:40]);
                                n_out.weekday      = shifted[35:32];
                                n_out.hour         = dec_hour;
                                n_out.minute       = f_two(shifted[23:20], shifted[19:16]);
                                n_out.second       = f_two(shifted[15:12], shifted[11:8]);
                                n_out.hundredths   = f_two(shifted[7:4], shifted[3:0]);
                            end
                        end else begin
                            n_bits = r_bits - 6'd1;
                        end
                    end
                    if (shifted == UNLOCK_KEY) begin
                        n_oshift   = snap_word;
                        n_match    = '0;
                        n_bits     = FULL_COUNT;
                        n_unlocked = 1'b1;
                    end
                end
                REQ_RD: begin
                    n_out.read_bit = r_oshift[0];
                    if (r_bits != 6'd0) begin
                        n_oshift = {1'b0, r_oshift[63:1]};
                        n_bits   = r_bits - 6'd1;
                    end else begin
                        n_unlocked = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match    <= '0;
            r_oshift   <= '0;
            r_bits     <= '0;
            r_unlocked <= 1'b0;
            r_twelve   <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            r_match    <= n_match;
            r_oshift   <= n_oshift;
            r_bits     <= n_bits;
            r_unlocked <= n_unlocked;
            r_twelve   <= n_twelve;
            if (fire) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_valid                = r_out_v;
    assign o_read_bit             = r_out.read_bit;
    assign o_time_written         = r_out.time_written;
    assign o_set_years_since_1900 = r_out.years;
    assign o_set_month            = r_out.month;
    assign o_set_day              = r_out.day;
    assign o_set_weekday          = r_out.weekday;
    assign o_set_hour             = r_out.hour;
    assign o_set_minute           = r_out.minute;
    assign o_set_second           = r_out.second;
    assign o_set_hundredths       = r_out.hundredths;

    a_count_needs_unlock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bits != 6'd0) |-> r_unlocked)
        else $error("bit counter running while locked");

    a_key_unlocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && is_wr && (shifted == UNLOCK_KEY)) |=> (r_unlocked && (r_bits == FULL_COUNT)
            && (r_match == 64'd0)))
        else $error("key match did not unlock");

    a_write_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_time_written) |-> !o_read_bit)
        else $error("time write result carries a read bit");

    a_quiet_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_time_written) |-> ((o_set_hour == 6'd0) && (o_set_weekday == 4'd0)
            && (o_set_years_since_1900 == 8'd0) && (o_set_hundredths == 8'd0)))
        else $error("set fields nonzero without a time write");

endmodule

`default_nettype wire
